// ===== hdl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 64;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);
    localparam int SHIFT_W  = 7;

    localparam int CMD_W     = 2;
    localparam int ADDR_W    = 64;
    localparam int OUTCOME_W = 2;
    localparam int CNT_W     = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SB_W       = 3;
    localparam int WAYS_W     = 4;
    localparam int BB_W       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] tag;
        logic [AGE_W-1:0]     age;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

endpackage

// ===== hdl/salc_if.sv =====
// ----------------------------------------------------------------------------
// salc_if
// Valid/ready channels of the cache model: access, result and config write.
// ----------------------------------------------------------------------------
interface salc_acc_if import salc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface salc_res_if import salc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic                 second_hit;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     evict_total;

    modport source (output valid, output outcome, output second_hit, output hit_total,
                    output miss_total, output evict_total, input ready);
    modport sink   (input valid, input outcome, input second_hit, input hit_total,
                    input miss_total, input evict_total, output ready);
endinterface

interface salc_cfg_if import salc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: accepts a request, then commits the lookup once the result
// register is free.
// ----------------------------------------------------------------------------
module salc_ctrl import salc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        out_free     = !r_out_valid || i_out_ready;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/salc_dp.sv =====
// ----------------------------------------------------------------------------
// salc_dp
// Datapath: config registers, address split, set memory, tag compare,
// LRU update, saturating totals and result register.
// ----------------------------------------------------------------------------
module salc_dp import salc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_acc_cmd,
    input  logic [ADDR_W-1:0]     i_acc_address,
    output logic [OUTCOME_W-1:0]  o_outcome,
    output logic                  o_second_hit,
    output logic [CNT_W-1:0]      o_hit_total,
    output logic [CNT_W-1:0]      o_miss_total,
    output logic [CNT_W-1:0]      o_evict_total
);

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, c} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    logic [SB_W-1:0]   r_set_bits;
    logic [WAYS_W-1:0] r_ways;
    logic [BB_W-1:0]   r_block_bits;

    t_row              r_mem [NUM_SETS];
    logic [NUM_SETS-1:0] r_row_wr;
    t_row              r_rd_row;
    logic              r_rd_fresh;
    logic [SET_W-1:0]  r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [CMD_W-1:0]  r_cmd;

    logic [CNT_W-1:0]  r_hits, r_misses, r_evicts;
    logic [CNT_W-1:0]  n_hits, n_misses, n_evicts;

    logic [SB_W-1:0]      sb;
    logic [SHIFT_W-1:0]   shift;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] addr_sh;
    logic [SET_W:0]       mask_w;
    logic [SET_W-1:0]     rd_set;
    logic [ADDR_BITS-1:0] in_tag;

    logic [NW_W-1:0]      nw;
    logic [NW_W-1:0]      ref_rank;
    logic [MAX_WAYS-1:0]  in_use;
    t_row                 eff_row, n_row;
    logic                 hit, free_found, cmd_ok, is_mod;
    logic [WAY_W-1:0]     hit_w, free_w, victim, sel_w;
    logic [AGE_W-1:0]     oldest;
    logic [OUTCOME_W-1:0] n_outcome;
    logic [1:0]           inc_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_ways       <= WAYS_W'(1);
            r_block_bits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SB_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sb      = (32'(r_set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : r_set_bits;
        shift   = SHIFT_W'(sb) + SHIFT_W'(r_block_bits);
        addr    = i_acc_address[ADDR_BITS-1:0];
        addr_sh = addr >> r_block_bits;
        mask_w  = ({{SET_W{1'b0}}, 1'b1} << sb) - 1'b1;
        rd_set  = addr_sh[SET_W-1:0] & mask_w[SET_W-1:0];
        in_tag  = (32'(shift) >= ADDR_BITS) ? '0 : (addr >> shift);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_row <= r_mem[rd_set];
            r_set    <= rd_set;
            r_tag    <= in_tag;
            r_cmd    <= i_acc_cmd;
        end
        if (i_cmd.commit && cmd_ok) begin
            r_mem[r_set] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_wr   <= '0;
            r_rd_fresh <= 1'b0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_evicts   <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_rd_fresh <= r_row_wr[rd_set];
            end
            if (i_cmd.commit) begin
                if (cmd_ok) begin
                    r_row_wr[r_set] <= 1'b1;
                end
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
            end
        end
    end

    always_comb begin
        if (r_ways == '0) begin
            nw = NW_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            nw = NW_W'(MAX_WAYS);
        end else begin
            nw = NW_W'(r_ways);
        end

        eff_row    = r_rd_fresh ? r_rd_row : '0;
        hit        = 1'b0;
        hit_w      = '0;
        free_found = 1'b0;
        free_w     = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = NW_W'(i) < nw;
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (in_use[i] && eff_row[i].valid && eff_row[i].tag == r_tag) begin
                hit   = 1'b1;
                hit_w = WAY_W'(i);
            end
            if (in_use[i] && !eff_row[i].valid) begin
                free_found = 1'b1;
                free_w     = WAY_W'(i);
            end
        end

        victim = '0;
        oldest = eff_row[0].age;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && eff_row[i].age > oldest) begin
                oldest = eff_row[i].age;
                victim = WAY_W'(i);
            end
        end

        sel_w    = hit ? hit_w : (free_found ? free_w : victim);
        ref_rank = hit ? NW_W'(eff_row[sel_w].age) : nw;

        n_row = eff_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (in_use[i] && WAY_W'(i) != sel_w && eff_row[i].valid &&
                NW_W'(eff_row[i].age) < ref_rank &&
                NW_W'(eff_row[i].age) < nw - 1'b1) begin
                n_row[i].age = eff_row[i].age + 1'b1;
            end
        end
        n_row[sel_w].age   = '0;
        n_row[sel_w].valid = 1'b1;
        n_row[sel_w].tag   = r_tag;

        cmd_ok = (r_cmd == CMD_LOAD) || (r_cmd == CMD_STORE) || (r_cmd == CMD_MODIFY);
        is_mod = (r_cmd == CMD_MODIFY);

        if (!cmd_ok) begin
            n_outcome = OUT_HIT;
        end else if (hit) begin
            n_outcome = OUT_HIT;
        end else if (free_found) begin
            n_outcome = OUT_MISS;
        end else begin
            n_outcome = OUT_EVICT;
        end

        inc_hit  = {1'b0, cmd_ok && hit} + {1'b0, is_mod};
        n_hits   = sat_add(r_hits, inc_hit);
        n_misses = sat_add(r_misses, {1'b0, cmd_ok && !hit});
        n_evicts = sat_add(r_evicts, {1'b0, cmd_ok && !hit && !free_found});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_outcome     <= n_outcome;
            o_second_hit  <= is_mod;
            o_hit_total   <= n_hits;
            o_miss_total  <= n_misses;
            o_evict_total <= n_evicts;
        end
    end

endmodule

// ===== hdl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache with LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_acc    in   valid/ready    cmd, address
//  o_res    out  valid/ready    outcome, second_hit, hit/miss/evict totals
//  i_cfg    in   valid/ready    index, data (ready always high)
//
//  On accept the set's row is read from the set memory; the commit edge
//  compares tags, writes the row back and loads the result register.
//  A modify is finished in the same pass.
//  Reset is synchronous; per-set row flags clear at once, no clearing pass.
//  While the result register is still full the lookup holds until taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim import salc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    salc_acc_if.sink    i_acc,
    salc_res_if.source  o_res,
    salc_cfg_if.sink    i_cfg
);

    t_dp_cmd dp_cmd;

    assign i_cfg.ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_acc.valid),
        .o_in_ready  (i_acc.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd)
    );

    salc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_acc_cmd     (i_acc.cmd),
        .i_acc_address (i_acc.address),
        .o_outcome     (o_res.outcome),
        .o_second_hit  (o_res.second_hit),
        .o_hit_total   (o_res.hit_total),
        .o_miss_total  (o_res.miss_total),
        .o_evict_total (o_res.evict_total)
    );

endmodule

// ===== dv/tb_set_assoc_lru_cache_sim.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim
// Self-checking bench for the tag-only set-associative LRU cache. A shadow
// tag store with its own LRU ranks and saturating totals predicts every
// result; directed cases cover the reset geometry, rank ties and clamped
// register values, then random traffic runs over many geometries under
// random idling and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim;
    import salc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 150;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic                 second_hit;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
        logic [CNT_W-1:0]     evicts;
    } t_access_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    salc_acc_if acc_ch();
    salc_res_if res_ch();
    salc_cfg_if cfg_ch();

    set_assoc_lru_cache_sim u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [SB_W-1:0]   geo_set_bits;
    logic [WAYS_W-1:0] geo_ways;
    logic [BB_W-1:0]   geo_block_bits;

    logic             way_valid [NUM_SETS][MAX_WAYS];
    logic [ADDR_W-1:0] way_tag  [NUM_SETS][MAX_WAYS];
    logic [AGE_W-1:0] way_rank  [NUM_SETS][MAX_WAYS];
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;
    logic [CNT_W-1:0] evict_cnt;

    t_access_report reports_in_flight[$];
    int             fail_count     = 0;
    int             cycle_count    = 0;
    bit             src_gaps_on    = 1'b1;
    bit             sink_stalls_on = 1'b1;
    bit             hold_requested = 1'b0;

    function automatic int unsigned ways_in_use();
        if (geo_ways == 0) return 1;
        if (geo_ways > MAX_WAYS) return MAX_WAYS;
        return geo_ways;
    endfunction

    function automatic int unsigned set_bits_in_use();
        return (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : geo_set_bits;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic void promote(int unsigned set, int unsigned way, int unsigned nw,
                                    int unsigned old_rank);
        for (int unsigned i = 0; i < nw; i++) begin
            if (i != way && way_valid[set][i] && way_rank[set][i] < old_rank) begin
                if (way_rank[set][i] < nw - 1) way_rank[set][i] = way_rank[set][i] + 1'b1;
            end
        end
        way_rank[set][way] = '0;
    endfunction

    function automatic logic [OUTCOME_W-1:0] probe(int unsigned set, logic [ADDR_W-1:0] tag);
        int unsigned nw;
        int unsigned victim;
        int unsigned oldest;
        nw = ways_in_use();
        for (int unsigned i = 0; i < nw; i++) begin
            if (way_valid[set][i] && way_tag[set][i] == tag) begin
                promote(set, i, nw, way_rank[set][i]);
                hit_cnt = sat_inc(hit_cnt);
                return OUT_HIT;
            end
        end
        for (int unsigned i = 0; i < nw; i++) begin
            if (!way_valid[set][i]) begin
                way_valid[set][i] = 1'b1;
                way_tag[set][i]   = tag;
                promote(set, i, nw, nw);
                miss_cnt = sat_inc(miss_cnt);
                return OUT_MISS;
            end
        end
        victim = 0;
        oldest = way_rank[set][0];
        for (int unsigned i = 1; i < nw; i++) begin
            if (way_rank[set][i] > oldest) begin
                oldest = way_rank[set][i];
                victim = i;
            end
        end
        way_tag[set][victim] = tag;
        promote(set, victim, nw, nw);
        miss_cnt  = sat_inc(miss_cnt);
        evict_cnt = sat_inc(evict_cnt);
        return OUT_EVICT;
    endfunction

    function automatic t_access_report apply_access(logic [CMD_W-1:0] cmd,
                                                    logic [ADDR_W-1:0] addr);
        int unsigned    sb;
        int unsigned    shift;
        int unsigned    set;
        logic [ADDR_W-1:0] tag;
        t_access_report r;
        sb    = set_bits_in_use();
        shift = sb + geo_block_bits;
        set   = 32'((addr >> geo_block_bits) & 64'((1 << sb) - 1));
        tag   = (shift >= ADDR_W) ? '0 : (addr >> shift);
        r.outcome    = OUT_HIT;
        r.second_hit = 1'b0;
        if (cmd == CMD_LOAD || cmd == CMD_STORE || cmd == CMD_MODIFY) begin
            r.outcome = probe(set, tag);
            if (cmd == CMD_MODIFY) r.second_hit = (probe(set, tag) == OUT_HIT);
        end
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        r.evicts = evict_cnt;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] build_address(logic [ADDR_W-1:0] tag,
                                                        int unsigned set);
        int unsigned       sb;
        int unsigned       bb;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] addr;
        sb       = set_bits_in_use();
        bb       = geo_block_bits;
        low_mask = (bb == 0) ? '0 : ({ADDR_W{1'b1}} >> (ADDR_W - bb));
        addr     = {$urandom, $urandom} & low_mask;
        addr     = addr | (64'(set & ((1 << sb) - 1)) << bb);
        if (sb + bb < ADDR_W) addr = addr | (tag << (sb + bb));
        return addr;
    endfunction

    function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (reports_in_flight.size() == 0) begin
                fail_count++;
                $display("%0t: result with no request outstanding", $time);
            end else begin
                t_access_report r;
                r = reports_in_flight.pop_front();
                compare_field("outcome", r.outcome, res_ch.outcome);
                compare_field("second_hit", r.second_hit, res_ch.second_hit);
                compare_field("hit_total", r.hits, res_ch.hit_total);
                compare_field("miss_total", r.misses, res_ch.miss_total);
                compare_field("evict_total", r.evicts, res_ch.evict_total);
            end
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requested) begin
                hold_requested = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        acc_ch.valid   <= 1'b1;
        acc_ch.cmd     <= cmd;
        acc_ch.address <= addr;
        @(posedge i_clk);
        while (!acc_ch.ready) @(posedge i_clk);
        reports_in_flight.push_back(apply_access(cmd, addr));
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            acc_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_reports();
        acc_ch.valid <= 1'b0;
        while (reports_in_flight.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (index)
            CFG_SET_BITS:   geo_set_bits   = SB_W'(value);
            CFG_WAYS:       geo_ways       = WAYS_W'(value);
            CFG_BLOCK_BITS: geo_block_bits = BB_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned sb, int unsigned nw, int unsigned bb);
        drain_reports();
        write_register(CFG_SET_BITS, sb);
        write_register(CFG_WAYS, nw);
        write_register(CFG_BLOCK_BITS, bb);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_access(logic [ADDR_W-1:0] tag_base, int unsigned set_base);
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        int unsigned       roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) cmd = CMD_UNKNOWN;
        else if (roll < 7) cmd = CMD_LOAD;
        else if (roll < 13) cmd = CMD_STORE;
        else cmd = CMD_MODIFY;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            addr = {$urandom, $urandom};
        end else if (roll < 25) begin
            addr = build_address(tag_base + $urandom_range(0, 15), $urandom);
        end else begin
            addr = build_address(tag_base + $urandom_range(0, ways_in_use() + 1),
                                 set_base + $urandom_range(0, 1));
        end
        send_access(cmd, addr);
    endtask

    task automatic run_traffic(int unsigned n_items);
        logic [ADDR_W-1:0] tag_base;
        int unsigned       set_base;
        tag_base = {$urandom, $urandom};
        set_base = $urandom;
        for (int unsigned i = 0; i < n_items; i++) begin
            send_random_access(tag_base, set_base);
        end
    endtask

    // one way, one set: every address is its own tag
    task automatic test_reset_geometry();
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_STORE, {ADDR_W{1'b1}});
        send_access(CMD_MODIFY, {ADDR_W{1'b1}});
        send_access(CMD_MODIFY, 64'h5555_5555_5555_5555);
        send_access(CMD_UNKNOWN, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    // shrink then regrow the way count so two valid ways share the oldest rank
    task automatic test_lru_ties();
        set_geometry(0, 4, 0);
        send_access(CMD_LOAD, 64'd1);
        send_access(CMD_STORE, 64'd2);
        send_access(CMD_MODIFY, 64'd3);
        set_geometry(0, 1, 0);
        send_access(CMD_LOAD, 64'd5);
        set_geometry(0, 4, 0);
        send_access(CMD_LOAD, 64'd6);
        send_access(CMD_STORE, 64'd7);
        send_access(CMD_LOAD, 64'd8);
    endtask

    // oversized set count and way count, tag shift past the address width, zero ways
    task automatic test_geometry_clamps();
        set_geometry(7, 15, 63);
        send_access(CMD_LOAD, {ADDR_W{1'b1}});
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_MODIFY, 64'h8000_0000_0000_0000);
        set_geometry(0, 0, 0);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_STORE, 64'h1);
    endtask

    task automatic test_random_geometries();
        int unsigned fixed_sb [8] = '{2, 6, 7, 0, 3, 1, 5, 4};
        int unsigned fixed_nw [8] = '{4, 8, 15, 0, 2, 8, 3, 9};
        int unsigned fixed_bb [8] = '{4, 6, 0, 63, 58, 32, 10, 1};
        for (int p = 0; p < 12; p++) begin
            if (p < 8) set_geometry(fixed_sb[p], fixed_nw[p], fixed_bb[p]);
            else set_geometry($urandom_range(0, 7), $urandom_range(0, 15),
                              $urandom_range(0, 63));
            run_traffic(90);
        end
    endtask

    // hold results until the block backs up, then pause the sender until all is back
    task automatic test_backpressure();
        set_geometry(2, 4, 3);
        hold_requested = 1'b1;
        run_traffic(60);
        drain_reports();
        run_traffic(40);
    endtask

    task automatic test_full_rate();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_geometry(3, 8, 5);
        run_traffic(150);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        acc_ch.valid   <= 1'b0;
        acc_ch.cmd     <= CMD_LOAD;
        acc_ch.address <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_SET_BITS;
        cfg_ch.data    <= '0;
        geo_set_bits   = '0;
        geo_ways       = WAYS_W'(1);
        geo_block_bits = '0;
        hit_cnt        = '0;
        miss_cnt       = '0;
        evict_cnt      = '0;
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                way_valid[s][w] = 1'b0;
                way_tag[s][w]   = '0;
                way_rank[s][w]  = '0;
            end
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_lru_ties();
        test_geometry_clamps();
        test_random_geometries();
        test_backpressure();
        test_full_rate();

        drain_reports();
        repeat (8) @(posedge i_clk);
        fail_count += reports_in_flight.size();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== set_assoc_lru_cache_sim.f =====
hdl/salc_pkg.sv
hdl/salc_if.sv
hdl/salc_ctrl.sv
hdl/salc_dp.sv
hdl/set_assoc_lru_cache_sim.sv
dv/tb_set_assoc_lru_cache_sim.sv
